// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

    localparam int KEY_W      = 34;
    localparam int TAG_W      = 32;
    localparam int SLOT_W     = 4;
    localparam int DIGIT_W    = 4;
    localparam int HASH_STEPS = 9;
    localparam int KEY_PAD_W  = HASH_STEPS * DIGIT_W;
    localparam int HCNT_W     = 4;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_PROBE  = 6'b001000,
        S_MOVE   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

endpackage

// ===== rtl/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Linear-probing hash table of TABLE_SIZE slots, each holding a 34-bit key and a 32-bit
// name tag in one synchronous RAM (one write port, one registered read port). After reset
// a clearing pass empties every slot in turn; in_ready stays low meanwhile.
// One command is worked at a time: the home slot (key mod TABLE_SIZE) is formed four
// key bits per cycle, then the RAM is read one slot per cycle from home with
// wrap-around, each read answered in the next cycle, until the slot is decided. The
// unused command code is answered without hashing or probing. in_ready returns as the
// result is loaded, together with out_valid. The result sits in an output register,
// so the next command is taken while it waits.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       command,
    input  logic [KEY_W-1:0] key,
    input  logic [TAG_W-1:0] name_tag,
    input  logic             replace_mode,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [SLOT_W-1:0] slot,
    output logic             displaced
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam int RW = AW + DIGIT_W;
    localparam int W  = 1 + AW + KEY_W + TAG_W;

    localparam logic [RW-1:0] N1 = RW'(TABLE_SIZE);
    localparam logic [RW-1:0] N2 = RW'(2 * TABLE_SIZE);
    localparam logic [RW-1:0] N4 = RW'(4 * TABLE_SIZE);
    localparam logic [RW-1:0] N8 = RW'(8 * TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] ALL_CNT  = CW'(TABLE_SIZE);

    // One radix-16 step of key mod TABLE_SIZE: input below 16 * TABLE_SIZE.
    function automatic logic [AW-1:0] mod_step(input logic [RW-1:0] t);
        logic [RW-1:0] v;
        v = t;
        if (v >= N8) v = v - N8;
        if (v >= N4) v = v - N4;
        if (v >= N2) v = v - N2;
        if (v >= N1) v = v - N1;
        return v[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic                  repl_reg, repl_next;
    logic [KEY_PAD_W-1:0]  key_sh_reg, key_sh_next;
    logic [HCNT_W-1:0]     hash_cnt_reg, hash_cnt_next;
    logic [AW-1:0]         home_reg, home_next;
    logic [AW-1:0]         issue_idx_reg, issue_idx_next;
    logic [CW-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [AW-1:0]         rsp_idx_reg, rsp_idx_next;
    logic [CW-1:0]         rsp_cnt_reg, rsp_cnt_next;
    logic [AW-1:0]         occ_home_reg, occ_home_next;
    logic [KEY_W-1:0]      occ_key_reg, occ_key_next;
    logic [TAG_W-1:0]      occ_tag_reg, occ_tag_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [AW-1:0]         res_slot_reg, res_slot_next;
    logic                  res_displaced_reg, res_displaced_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg, status_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  displaced_reg, displaced_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [W-1:0]          ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [W-1:0]          ram_rdata;

    logic                  d_valid;
    logic [AW-1:0]         d_home;
    logic [KEY_W-1:0]      d_key;
    logic [TAG_W-1:0]      d_tag;
    logic                  hit;
    logic                  last_rsp;
    logic [AW-1:0]         hash_val;
    logic [AW+SLOT_W-1:0]  slot_ext;

    lpht_ram #(
        .WIDTH (W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign d_valid  = ram_rdata[W-1];
    assign d_home   = ram_rdata[W-2 -: AW];
    assign d_key    = ram_rdata[KEY_W+TAG_W-1 -: KEY_W];
    assign d_tag    = ram_rdata[TAG_W-1:0];
    assign hit      = d_valid && (d_key == key_reg);
    assign last_rsp = (rsp_cnt_reg == LAST_CNT);
    assign hash_val = mod_step({home_reg, key_sh_reg[KEY_PAD_W-1 -: DIGIT_W]});
    assign slot_ext = {{SLOT_W{1'b0}}, res_slot_reg};

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        key_next           = key_reg;
        tag_next           = tag_reg;
        repl_next          = repl_reg;
        key_sh_next        = key_sh_reg;
        hash_cnt_next      = hash_cnt_reg;
        home_next          = home_reg;
        issue_idx_next     = issue_idx_reg;
        issue_cnt_next     = issue_cnt_reg;
        rsp_valid_next     = 1'b0;
        rsp_idx_next       = rsp_idx_reg;
        rsp_cnt_next       = rsp_cnt_reg;
        occ_home_next      = occ_home_reg;
        occ_key_next       = occ_key_reg;
        occ_tag_next       = occ_tag_reg;
        res_status_next    = res_status_reg;
        res_slot_next      = res_slot_reg;
        res_displaced_next = res_displaced_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        status_next        = status_reg;
        slot_next          = slot_reg;
        displaced_next     = displaced_reg;
        clr_idx_next       = clr_idx_reg;
        ram_we             = 1'b0;
        ram_waddr          = rsp_idx_reg;
        ram_wdata          = '0;
        ram_raddr          = issue_idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = next_idx(clr_idx_reg);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next           = cmd_t'(command);
                    key_next           = key;
                    tag_next           = name_tag;
                    repl_next          = replace_mode;
                    key_sh_next        = {{(KEY_PAD_W-KEY_W){1'b0}}, key};
                    hash_cnt_next      = '0;
                    home_next          = '0;
                    res_status_next    = ST_MISSING;
                    res_slot_next      = '0;
                    res_displaced_next = 1'b0;
                    case (cmd_t'(command))
                        CMD_INSERT, CMD_SEARCH, CMD_DELETE: state_next = S_HASH;
                        default:                            state_next = S_FINISH;
                    endcase
                end
            end
            S_HASH:
            begin
                // home_reg accumulates the running remainder
                home_next     = hash_val;
                key_sh_next   = key_sh_reg << DIGIT_W;
                hash_cnt_next = hash_cnt_reg + 1'b1;
                if (hash_cnt_reg == HCNT_W'(HASH_STEPS - 1))
                begin
                    issue_idx_next = hash_val;
                    issue_cnt_next = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (issue_cnt_reg != ALL_CNT)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_idx_next   = issue_idx_reg;
                    rsp_cnt_next   = issue_cnt_reg;
                    issue_idx_next = next_idx(issue_idx_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (rsp_valid_reg)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (rsp_cnt_reg == '0)
                            begin
                                if (!d_valid)
                                begin
                                    ram_we          = 1'b1;
                                    ram_wdata       = {1'b1, home_reg, key_reg, tag_reg};
                                    res_status_next = ST_DONE;
                                    res_slot_next   = rsp_idx_reg;
                                    state_next      = S_FINISH;
                                end
                                else
                                begin
                                    // hold the home occupant in case it has to move
                                    occ_home_next = d_home;
                                    occ_key_next  = d_key;
                                    occ_tag_next  = d_tag;
                                end
                            end
                            else if (!d_valid)
                            begin
                                ram_we          = 1'b1;
                                res_status_next = ST_DONE;
                                if (repl_reg && (occ_home_reg != home_reg))
                                begin
                                    ram_wdata          = {1'b1, occ_home_reg, occ_key_reg,
                                                          occ_tag_reg};
                                    res_slot_next      = home_reg;
                                    res_displaced_next = 1'b1;
                                    state_next         = S_MOVE;
                                end
                                else
                                begin
                                    ram_wdata     = {1'b1, home_reg, key_reg, tag_reg};
                                    res_slot_next = rsp_idx_reg;
                                    state_next    = S_FINISH;
                                end
                            end
                            else if (last_rsp)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_FINISH;
                            end
                        end
                        CMD_SEARCH, CMD_DELETE:
                        begin
                            if (hit)
                            begin
                                // an all-zero word marks the slot empty
                                ram_we          = (cmd_reg == CMD_DELETE);
                                res_status_next = ST_DONE;
                                res_slot_next   = rsp_idx_reg;
                                state_next      = S_FINISH;
                            end
                            else if (last_rsp)
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = home_reg;
                ram_wdata  = {1'b1, home_reg, key_reg, tag_reg};
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    slot_next      = slot_ext[SLOT_W-1:0];
                    displaced_next = res_displaced_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        key_reg           <= key_next;
        tag_reg           <= tag_next;
        repl_reg          <= repl_next;
        key_sh_reg        <= key_sh_next;
        hash_cnt_reg      <= hash_cnt_next;
        home_reg          <= home_next;
        issue_idx_reg     <= issue_idx_next;
        issue_cnt_reg     <= issue_cnt_next;
        rsp_idx_reg       <= rsp_idx_next;
        rsp_cnt_reg       <= rsp_cnt_next;
        occ_home_reg      <= occ_home_next;
        occ_key_reg       <= occ_key_next;
        occ_tag_reg       <= occ_tag_next;
        res_status_reg    <= res_status_next;
        res_slot_reg      <= res_slot_next;
        res_displaced_reg <= res_displaced_next;
        status_reg        <= status_next;
        slot_reg          <= slot_next;
        displaced_reg     <= displaced_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign displaced = displaced_reg;

    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ram_we)
        else $error("table written while taking a new command");

    a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second command taken before the first finished");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_DONE)) |-> ((slot == '0) && !displaced))
        else $error("failed command reports a slot or a move");

    a_move_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> ((cmd_reg == CMD_INSERT) && repl_reg))
        else $error("occupant move outside a replacing insert");

endmodule
